[rtl/gptu_pkg.sv]
// ---------------------------------------------------------------------------
// gptu_pkg: shared types and codes of the packet tag unpacker
// Result kinds, data formats, descriptor codes, state and result records.
// ---------------------------------------------------------------------------
package gptu_pkg;

	localparam int WordW  = 64;
	localparam int KindW  = 3;
	localparam int RegW   = 8;
	localparam int LoopW  = 15;
	localparam int DescW  = 4;
	localparam int DCntW  = 5;
	localparam int FmtW   = 2;
	localparam int PrimW  = 11;

	typedef enum logic [KindW-1:0] {
		KIND_PRIM   = 3'd0,
		KIND_REG    = 3'd1,
		KIND_HW     = 3'd2,
		KIND_UNIMPL = 3'd3,
		KIND_BADFMT = 3'd4
	} kind_t;

	localparam logic [FmtW-1:0] FMT_PACKED = 2'd0;
	localparam logic [FmtW-1:0] FMT_BAD    = 2'd1;

	localparam logic [DescW-1:0] DESC_PRIM  = 4'h0;
	localparam logic [DescW-1:0] DESC_ADDR  = 4'hE;
	localparam logic [DescW-1:0] DESC_LAST_UNIMPL = 4'h5;
	localparam logic [DescW-1:0] DESC_UNIMPL_A    = 4'hA;
	localparam logic [DescW-1:0] DESC_UNIMPL_F    = 4'hF;

	localparam logic [DCntW-1:0] FULL_LIST = 5'd16;

	typedef struct packed {
		logic [LoopW-1:0] loops_left;
		logic [DCntW-1:0] descriptors_left;
		logic [DCntW-1:0] descriptor_count;
		logic [FmtW-1:0]  data_format;
		logic [WordW-1:0] descriptor_list;
	} state_t;

	typedef struct packed {
		kind_t            kind;
		logic [RegW-1:0]  target;
		logic [WordW-1:0] data;
		logic             last;
	} result_t;

endpackage

[rtl/gptu_if.sv]
// ---------------------------------------------------------------------------
// gptu_qword_if / gptu_result_if: valid/ready channels of the unpacker
// One beat moves a qword on the input side and one result on the output.
// ---------------------------------------------------------------------------
interface gptu_qword_if;
	logic        valid;
	logic        ready;
	logic [63:0] word_low;
	logic [63:0] word_high;

	modport source (output valid, output word_low, output word_high, input ready);
	modport sink   (input valid, input word_low, input word_high, output ready);
endinterface

interface gptu_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  write_kind;
	logic [7:0]  target_register;
	logic [63:0] write_data;
	logic        last;

	modport source (output valid, output write_kind, output target_register,
		output write_data, output last, input ready);
	modport sink   (input valid, input write_kind, input target_register,
		input write_data, input last, output ready);
endinterface

[rtl/gptu_decode.sv]
// ---------------------------------------------------------------------------
// gptu_decode: tag and data decode of one qword
// Computes the next unpacker state and up to two results from one qword.
// ---------------------------------------------------------------------------
module gptu_decode (
	input  gptu_pkg::state_t  state,
	input  logic [63:0]       word_low,
	input  logic [63:0]       word_high,
	output gptu_pkg::state_t  state_nx,
	output gptu_pkg::result_t res0,
	output gptu_pkg::result_t res1,
	output logic [1:0]        res_cnt
);
	import gptu_pkg::*;

	logic [LoopW-1:0] nloop;
	logic [DCntW-1:0] tag_cnt;
	logic [DCntW-1:0] dpos;
	logic [DescW-1:0] dsc;
	logic [DCntW-1:0] dleft_dec;

	assign nloop     = word_low[LoopW-1:0];
	assign tag_cnt   = (word_low[63:60] == '0) ? FULL_LIST : {1'b0, word_low[63:60]};
	assign dpos      = state.descriptor_count - state.descriptors_left;
	assign dsc       = state.descriptor_list[{dpos[3:0], 2'b00} +: DescW];
	assign dleft_dec = state.descriptors_left - 1'b1;

	always_comb begin
		state_nx = state;
		res0     = '{kind: KIND_PRIM, target: '0, data: '0, last: 1'b1};
		res1     = '{kind: KIND_HW, target: '0, data: word_high, last: 1'b1};
		res_cnt  = 2'd0;
		if (state.loops_left == '0) begin
			if (nloop != '0) begin
				state_nx.loops_left       = nloop;
				state_nx.data_format      = word_low[59:58];
				state_nx.descriptor_count = tag_cnt;
				state_nx.descriptors_left = tag_cnt;
				state_nx.descriptor_list  = word_high;
				res0.data = {{(WordW-PrimW){1'b0}}, word_low[57:47]};
				res_cnt   = {1'b0, word_low[46]};
			end
		end else if (state.data_format == FMT_PACKED) begin
			res_cnt = 2'd1;
			if (dleft_dec == '0) begin
				state_nx.descriptors_left = state.descriptor_count;
				state_nx.loops_left       = state.loops_left - 1'b1;
			end else begin
				state_nx.descriptors_left = dleft_dec;
			end
			priority if (dsc == DESC_PRIM) begin
				res0.data = {{(WordW-PrimW){1'b0}}, word_low[PrimW-1:0]};
			end else if (dsc == DESC_ADDR) begin
				res0.kind   = KIND_REG;
				res0.target = word_high[RegW-1:0];
				res0.data   = word_low;
			end else if (dsc <= DESC_LAST_UNIMPL || dsc == DESC_UNIMPL_A
					|| dsc == DESC_UNIMPL_F) begin
				res0.kind = KIND_UNIMPL;
			end else begin
				res0.kind   = KIND_REG;
				res0.target = {{(RegW-DescW){1'b0}}, dsc};
				res0.data   = word_low;
			end
		end else if (state.data_format == FMT_BAD) begin
			res_cnt   = 2'd1;
			res0.kind = KIND_BADFMT;
		end else begin
			res_cnt   = 2'd2;
			res0.kind = KIND_HW;
			res0.data = word_low;
			res0.last = 1'b0;
			state_nx.loops_left = state.loops_left - 1'b1;
		end
	end

endmodule

[rtl/gptu_result_fifo.sv]
// ---------------------------------------------------------------------------
// gptu_result_fifo: three-entry result queue
// Takes up to two results per cycle and delivers one per beat.
// ---------------------------------------------------------------------------
module gptu_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  gptu_pkg::result_t res0,
	input  gptu_pkg::result_t res1,
	input  logic [1:0]        push_cnt,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output gptu_pkg::result_t out_res
);
	import gptu_pkg::*;

	localparam int Depth = 3;

	result_t    slot_q [Depth];
	logic [1:0] rd_ptr_q;
	logic [1:0] wr_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	logic [1:0] wr_ptr_nx1;

	function automatic logic [1:0] inc3(input logic [1:0] p);
		return (p == 2'd2) ? 2'd0 : p + 2'd1;
	endfunction

	assign out_valid  = (count_q != 2'd0);
	assign out_res    = slot_q[rd_ptr_q];
	assign pop        = out_valid && out_ready;
	assign room       = (count_q - {1'b0, pop}) <= 2'd1;
	assign wr_ptr_nx1 = inc3(wr_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= inc3(rd_ptr_q);
			end
			unique case (push_cnt)
				2'd0: wr_ptr_q <= wr_ptr_q;
				2'd1: wr_ptr_q <= wr_ptr_nx1;
				default: wr_ptr_q <= inc3(wr_ptr_nx1);
			endcase
			count_q <= count_q + push_cnt - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			slot_q[wr_ptr_q] <= res0;
		end
		if (push_cnt == 2'd2) begin
			slot_q[wr_ptr_nx1] <= res1;
		end
	end

endmodule

[rtl/graphics_packet_tag_unpacker_unit.sv]
// ---------------------------------------------------------------------------
// graphics_packet_tag_unpacker_unit: graphics packet tag unpacker
// Splits tagged 128-bit qword streams into register, primitive and image writes.
// ---------------------------------------------------------------------------
// Usage:
//   qword  : input channel, one 128-bit qword per beat (word_low, word_high).
//            With no loop pending the qword is a tag; otherwise it is data.
//   result : output channel, one write per beat (write_kind, target_register,
//            write_data, last). last marks the final write caused by a qword.
// Queue: a result is registered in the queue when its qword is accepted.
// Throughput: decode is one pass of logic from the unpacker state into a
//   three-entry result queue, so packed data and tags go at one qword per
//   cycle while the receiver is ready; image qwords give two writes each, so
//   the single result port holds them back.
// A tag with zero loop count, or a tag without primitive enable, gives no
//   result. In the unsupported format every qword gives an error result.
// Reset: clears the loop count (next qword is a tag) and empties the queue.
// Stall: the queue holds results while the receiver is not ready; qword
//   ready drops once fewer than two entries would be free.
// ---------------------------------------------------------------------------
module graphics_packet_tag_unpacker_unit (
	input logic             clk,
	input logic             arst_n,
	gptu_qword_if.sink      qword,
	gptu_result_if.source   result
);
	import gptu_pkg::*;

	state_t     state_q;
	state_t     state_nx;
	result_t    res0;
	result_t    res1;
	result_t    head;
	logic [1:0] res_cnt;
	logic       room;
	logic       take;

	// Accept a qword only when the queue can hold both writes it may cause.
	assign qword.ready = room;
	assign take        = qword.valid && room;

	gptu_decode u_decode (
		.state     (state_q),
		.word_low  (qword.word_low),
		.word_high (qword.word_high),
		.state_nx  (state_nx),
		.res0      (res0),
		.res1      (res1),
		.res_cnt   (res_cnt)
	);

	// Advance the unpacker state on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take) begin
			state_q <= state_nx;
		end
	end

	gptu_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.res0      (res0),
		.res1      (res1),
		.push_cnt  (take ? res_cnt : 2'd0),
		.room      (room),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_res   (head)
	);

	assign result.write_kind      = head.kind;
	assign result.target_register = head.target;
	assign result.write_data      = head.data;
	assign result.last            = head.last;

endmodule

[rtl/gptu_checker.sv]
// ---------------------------------------------------------------------------
// gptu_checker: port-level checks of the unpacker result channel
// Watches the result beats and flags malformed or dropped writes.
// ---------------------------------------------------------------------------
module gptu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  write_kind,
	input logic [7:0]  target_register,
	input logic [63:0] write_data,
	input logic        last
);
	import gptu_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(write_data))
		else $error("result data changed under stall");

	a_image_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_kind == KIND_HW && !last |=> out_valid)
		else $error("second image write not queued with the first");

	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_kind != KIND_REG |-> target_register == 8'd0)
		else $error("target register set on a non-register write");

	a_err_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (write_kind == KIND_UNIMPL || write_kind == KIND_BADFMT)
		|-> write_data == 64'd0 && last)
		else $error("error write carries data or is not last");

endmodule

bind graphics_packet_tag_unpacker_unit gptu_checker u_gptu_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.write_kind      (result.write_kind),
	.target_register (result.target_register),
	.write_data      (result.write_data),
	.last            (result.last)
);
